// ===== design/lek_pkg.sv =====
// Shared types and constants for the line-edit keystroke engine.
// No dependencies; imported by line_edit_keystroke_engine_core.
`timescale 1ns / 1ps

package lek_pkg;

    localparam int C_LINE_DEPTH = 128;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NOTIFY_LEVEL   = 3'd0;
    localparam logic [2:0] CFG_STORED_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_DISPLAY_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_ERASE_CHAR     = 3'd3;
    localparam logic [2:0] CFG_WORD_ERASE     = 3'd4;
    localparam logic [2:0] CFG_KILL_CHAR      = 3'd5;
    localparam logic [2:0] CFG_TERM_MASK_LOW  = 3'd6;
    localparam logic [2:0] CFG_TERM_MASK_HIGH = 3'd7;

    // Notify levels.
    localparam logic [1:0] NL_NONE      = 2'd0;
    localparam logic [1:0] NL_TERM_SET  = 2'd1;
    localparam logic [1:0] NL_NON_PRINT = 2'd2;
    localparam logic [1:0] NL_ALL       = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [1:0]  RST_NOTIFY_LEVEL   = NL_TERM_SET;
    localparam logic [7:0]  RST_STORED_LIMIT   = 8'd80;
    localparam logic [7:0]  RST_DISPLAY_LIMIT  = 8'd80;
    localparam logic [7:0]  RST_ERASE_CHAR     = 8'd127;
    localparam logic [7:0]  RST_WORD_ERASE     = 8'd23;
    localparam logic [7:0]  RST_KILL_CHAR      = 8'd21;
    localparam logic [63:0] RST_TERM_MASK_LOW  = 64'h0000_0000_0000_2600;
    localparam logic [63:0] RST_TERM_MASK_HIGH = 64'h0;

    // Character codes.
    localparam logic [7:0] C_TAB        = 8'd9;
    localparam logic [7:0] C_NEWLINE    = 8'd10;
    localparam logic [7:0] C_RETURN     = 8'd13;
    localparam logic [7:0] C_PRINT_LOW  = 8'd32;
    localparam logic [7:0] C_PRINT_HIGH = 8'd126;
    localparam logic [6:0] C_BLANK      = 7'd32;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_NEXT   = 2'd2,
        ACT_PREV   = 2'd3
    } t_action;

    typedef struct packed {
        logic [7:0] key_code;
        logic       shift_down;
    } t_key_item;

    typedef struct packed {
        logic       notified;
        t_action    action;
        logic       overflow;
        logic [7:0] line_length;
        logic [7:0] view_start;
    } t_key_result;

endpackage

// ===== design/line_edit_keystroke_engine_core.sv =====
// Line-edit keystroke engine: applies one key item to a stored text line.
// The result is registered: an accepted item passes through ST_FINISH to the output register;
// a word erase over n characters (n is at most LINE_DEPTH) first walks ST_SKIP_BLANK and
// ST_SKIP_WORD, since the single line-buffer read port and one decrement/compare unit step
// back one character a cycle. One item at a time: a new key waits until the result is loaded.
// Reset (synchronous, active low) empties the line and loads the register defaults.
`timescale 1ns / 1ps

module line_edit_keystroke_engine_core
    import lek_pkg::*;
#(
    parameter int LINE_DEPTH = C_LINE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_key_item   i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_key_result o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW   = $clog2(LINE_DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SKIP_BLANK,
        ST_SKIP_WORD,
        ST_FINISH
    } t_state;

    // Configuration registers.
    logic [1:0]  r_notify_level;
    logic [7:0]  r_stored_limit;
    logic [7:0]  r_display_limit;
    logic [7:0]  r_erase_char;
    logic [7:0]  r_word_erase;
    logic [7:0]  r_kill_char;
    logic [63:0] r_term_low;
    logic [63:0] r_term_high;

    // Line buffer and its registered read port.
    logic [6:0]  line_buffer [LINE_DEPTH];
    logic [6:0]  r_rdata;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    t_state      r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic        r_notified, n_notified;
    t_action     r_action, n_action;
    logic        r_overflow, n_overflow;
    logic        r_out_valid, n_out_valid;
    t_key_result r_out, n_out;

    // Key decode.
    logic [7:0]   code;
    logic         is_print;
    logic         is_term;
    logic         is_nav;
    logic         notify;
    t_action      action;
    logic         ok_insert;
    logic [127:0] term_mask;
    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] stored_ext;
    logic [CMPW-1:0] limit_ext;
    logic            room;

    // Clipping.
    logic [7:0]      disp;
    logic [CMPW-1:0] disp_ext;
    logic [CMPW-1:0] view_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_notify_level  <= RST_NOTIFY_LEVEL;
            r_stored_limit  <= RST_STORED_LIMIT;
            r_display_limit <= RST_DISPLAY_LIMIT;
            r_erase_char    <= RST_ERASE_CHAR;
            r_word_erase    <= RST_WORD_ERASE;
            r_kill_char     <= RST_KILL_CHAR;
            r_term_low      <= RST_TERM_MASK_LOW;
            r_term_high     <= RST_TERM_MASK_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NOTIFY_LEVEL:   r_notify_level  <= i_cfg_data[1:0];
                CFG_STORED_LIMIT:   r_stored_limit  <= i_cfg_data[7:0];
                CFG_DISPLAY_LIMIT:  r_display_limit <= i_cfg_data[7:0];
                CFG_ERASE_CHAR:     r_erase_char    <= i_cfg_data[7:0];
                CFG_WORD_ERASE:     r_word_erase    <= i_cfg_data[7:0];
                CFG_KILL_CHAR:      r_kill_char     <= i_cfg_data[7:0];
                CFG_TERM_MASK_LOW:  r_term_low      <= i_cfg_data;
                CFG_TERM_MASK_HIGH: r_term_high     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        code      = i_in_data.key_code;
        term_mask = {r_term_high, r_term_low};
        is_print  = (code >= C_PRINT_LOW) && (code <= C_PRINT_HIGH);
        is_term   = !code[7] && term_mask[code[6:0]];
        is_nav    = (code == C_NEWLINE) || (code == C_RETURN) || (code == C_TAB);

        unique case (r_notify_level)
            NL_NONE:      notify = 1'b0;
            NL_TERM_SET:  notify = is_term;
            NL_NON_PRINT: notify = !is_print;
            NL_ALL:       notify = 1'b1;
            default:      notify = 1'b0;
        endcase

        if (!notify) begin
            action = ACT_NONE;
        end else if (is_nav) begin
            action = i_in_data.shift_down ? ACT_PREV : ACT_NEXT;
        end else begin
            action = is_print ? ACT_INSERT : ACT_NONE;
        end
        ok_insert = notify ? (action == ACT_INSERT) : is_print;

        cnt_ext    = CMPW'(r_cnt);
        stored_ext = CMPW'(r_stored_limit);
        limit_ext  = (stored_ext < CMPW'(LINE_DEPTH)) ? stored_ext : CMPW'(LINE_DEPTH);
        room       = cnt_ext < limit_ext;

        disp     = (r_display_limit == 8'd0) ? 8'd1 : r_display_limit;
        disp_ext = CMPW'(disp);
        view_ext = (cnt_ext > disp_ext) ? (cnt_ext - disp_ext + CMPW'(1)) : '0;
    end

    // Sequencer: one decrement and one blank compare per cycle during a word erase.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_notified  = r_notified;
        n_action    = r_action;
        n_overflow  = r_overflow;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        wr_en       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_notified = notify;
                    n_action   = action;
                    n_overflow = 1'b0;
                    n_state    = ST_FINISH;
                    if (code == r_erase_char) begin
                        if (r_cnt != '0) begin
                            n_cnt = r_cnt - CW'(1);
                        end
                    end else if (code == r_word_erase) begin
                        n_state = ST_SKIP_BLANK;
                    end else if (code == r_kill_char) begin
                        n_cnt = '0;
                    end else if (ok_insert) begin
                        if (room) begin
                            wr_en = 1'b1;
                            n_cnt = r_cnt + CW'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end
                end
            end
            ST_SKIP_BLANK: begin
                // r_rdata holds the character just before r_cnt.
                if (r_cnt == '0) begin
                    n_state = ST_FINISH;
                end else if (r_rdata == C_BLANK) begin
                    n_cnt = r_cnt - CW'(1);
                end else begin
                    n_state = ST_SKIP_WORD;
                end
            end
            ST_SKIP_WORD: begin
                if (r_cnt == '0 || r_rdata == C_BLANK) begin
                    n_state = ST_FINISH;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid          = 1'b1;
                    n_out.notified       = r_notified;
                    n_out.action         = r_action;
                    n_out.overflow       = r_overflow;
                    n_out.line_length    = 8'(r_cnt);
                    n_out.view_start     = view_ext[7:0];
                    n_state              = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // Always fetch the character just below the next count.
        rd_addr = AW'(n_cnt - CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            line_buffer[r_cnt[AW-1:0]] <= code[6:0];
        end
        r_rdata <= line_buffer[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_notified <= n_notified;
        r_action   <= n_action;
        r_overflow <= n_overflow;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
